// ----- src/slm_pkg.sv -----
// Shared types and codes for the sorted list merge block.
package slm_pkg;

    localparam int VALUE_W = 32;

    // Command codes carried in the input tuser field.
    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_MERGE  = 2'd2
    } func_t;

    // Work handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_MERGE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [VALUE_W-1:0]   value;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 last;
        logic                 empty;
        logic                 overflow;
    } res_t;

endpackage

// ----- src/slm_front.sv -----
// Input stage: takes items, decodes the command and drops reserved codes.
module slm_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_func,
    input  logic [slm_pkg::VALUE_W-1:0] in_value,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output slm_pkg::cmd_t              cmd
);
    import slm_pkg::*;

    logic      cmd_valid_reg;
    logic      cmd_valid_next;
    cmd_t      cmd_reg;
    cmd_t      cmd_next;
    logic      known;
    cmd_kind_t kind;

    always_comb
    begin
        known = 1'b1;
        kind  = CMD_LOAD_A;
        unique case (in_func)
            FUNC_LOAD_A: kind = CMD_LOAD_A;
            FUNC_LOAD_B: kind = CMD_LOAD_B;
            FUNC_MERGE:  kind = CMD_MERGE;
            default:     known = 1'b0;
        endcase
    end

    assign in_ready = !cmd_valid_reg || cmd_ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next       = cmd_reg;
        if (in_valid && in_ready)
        begin
            cmd_valid_next = known;
            cmd_next.kind  = kind;
            cmd_next.value = in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ----- src/slm_queue.sv -----
// Small command queue between the front end and the back end.
module slm_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  slm_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output slm_pkg::cmd_t rd_cmd
);
    import slm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          do_wr;
    logic          do_rd;

    assign wr_ready = (fill_reg != CW'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- src/slm_back.sv -----
// Execution stage: list storage, merge walker and result register.
module slm_back
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  slm_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output slm_pkg::res_t res
);
    import slm_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

    logic [VALUE_W-1:0] list_a_reg [LIST_DEPTH];
    logic [VALUE_W-1:0] list_b_reg [LIST_DEPTH];

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] cnt_a_reg;
    logic [CW-1:0] cnt_a_next;
    logic [CW-1:0] cnt_b_reg;
    logic [CW-1:0] cnt_b_next;
    logic [CW-1:0] idx_a_reg;
    logic [CW-1:0] idx_a_next;
    logic [CW-1:0] idx_b_reg;
    logic [CW-1:0] idx_b_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          out_reg;
    res_t          out_next;

    logic               out_free;
    logic               take_cmd;
    logic               wr_a;
    logic               wr_b;
    logic               a_has;
    logic               b_has;
    logic               take_a;
    logic               is_last;
    logic [VALUE_W-1:0] head_a;
    logic [VALUE_W-1:0] head_b;

    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && ((cmd.kind != CMD_MERGE) || out_free);
    assign take_cmd  = cmd_valid && cmd_ready;

    assign head_a = list_a_reg[idx_a_reg[IW-1:0]];
    assign head_b = list_b_reg[idx_b_reg[IW-1:0]];
    assign a_has  = idx_a_reg < cnt_a_reg;
    assign b_has  = idx_b_reg < cnt_b_reg;
    // Ties go to the first list to keep the merge stable.
    assign take_a = a_has && (!b_has || ($signed(head_a) <= $signed(head_b)));
    assign is_last = ({1'b0, idx_a_reg} + {1'b0, idx_b_reg} + (CW+1)'(1))
                     == ({1'b0, cnt_a_reg} + {1'b0, cnt_b_reg});

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        wr_a           = 1'b0;
        wr_b           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_cmd)
                begin
                    case (cmd.kind)
                        CMD_LOAD_A:
                        begin
                            if (cnt_a_reg < CW'(LIST_DEPTH))
                            begin
                                wr_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B:
                        begin
                            if (cnt_b_reg < CW'(LIST_DEPTH))
                            begin
                                wr_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_MERGE:
                        begin
                            idx_a_next = '0;
                            idx_b_next = '0;
                            if (cnt_a_reg == '0 && cnt_b_reg == '0)
                            begin
                                out_valid_next    = 1'b1;
                                out_next.value    = '0;
                                out_next.last     = 1'b1;
                                out_next.empty    = 1'b1;
                                out_next.overflow = ovf_reg;
                                ovf_next          = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_MERGE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.value    = take_a ? head_a : head_b;
                    out_next.last     = is_last;
                    out_next.empty    = 1'b0;
                    out_next.overflow = ovf_reg;
                    if (take_a)
                    begin
                        idx_a_next = idx_a_reg + 1'b1;
                    end
                    else
                    begin
                        idx_b_next = idx_b_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            idx_a_reg     <= '0;
            idx_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            idx_a_reg     <= idx_a_next;
            idx_b_reg     <= idx_b_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (wr_a)
        begin
            list_a_reg[cnt_a_reg[IW-1:0]] <= cmd.value;
        end
        if (wr_b)
        begin
            list_b_reg[cnt_b_reg[IW-1:0]] <= cmd.value;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ----- src/sorted_list_merge.sv -----
// Two-way merge of sorted lists: top level.
//
// Input channel (s_axis_*): tuser selects the command (0 append to the
// first list, 1 append to the second list, 2 merge, 3 ignored), tdata
// carries the value to append. Appends give no output item.
// Output channel (m_axis_*): one item per stored element in ascending
// order, ties taking the first list first; tlast marks the final item of
// a merge. A merge of two empty lists gives one item flagged empty.
// Appends beyond LIST_DEPTH are dropped and flagged on the next merge.
//
// Throughput: one append per cycle while the input is not stalled; a merge
// emits one item per cycle while the receiver accepts, set by the walker
// reading both list heads and comparing them. An append passes the front
// register and the queue before it is stored; a merge command passes them,
// then the walker (unless both lists are empty) and the output register.
// The front end and back end are split by a two-entry command queue; with
// the front register it takes up to three items while a merge is walking.
// Reset clears both list counts, the overflow flag and all valid flags.
// When the receiver stalls, the output register holds its item and the
// walker pauses; the input stalls once the queue fills behind it.
module sorted_list_merge
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] merged_value
    output logic        m_axis_tlast,   // is_last
    output logic [1:0]  m_axis_tuser    // [0] is_empty, [1] load_overflow
);
    import slm_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;
    res_t res;

    slm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Decouples decode from execution.
    slm_queue #(.DEPTH(2)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_cmd   (back_cmd)
    );

    slm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = res.value;
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = {res.overflow, res.empty};

endmodule

// ----- src/slm_checker.sv -----
// Port-level checks for the sorted list merge block, bound to the top level.
module slm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // A stalled output item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

    // The empty marker comes alone, as the last item, with a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 32'd0))
    else $error("empty result malformed");

    // Items before the last of a merge are never marked empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[0])
    else $error("empty flag inside a merge");

    // The overflow flag is constant across one merge.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tuser[1] == $past(m_axis_tuser[1])))
    else $error("overflow flag changed within a merge");

endmodule

bind sorted_list_merge slm_checker u_slm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
